// ===== rtl/ffba_pkg.sv =====
// shared types, sizes and codes for the first-fit block allocator
// no dependencies; imported by ffba_ctrl, the top level and the testbench
`timescale 1ns / 1ps

package ffba_pkg;

    // heap geometry
    localparam int MAX_BLOCKS   = 64;
    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 32;

    // field and counter widths
    localparam int ADDR_W  = 16;                       // addresses and lengths
    localparam int SLOT_W  = $clog2(MAX_BLOCKS);       // slot index
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);   // slot count, holds MAX_BLOCKS
    localparam int BRK_W   = $clog2(HEAP_BYTES + 1);   // heap break, holds HEAP_BYTES
    localparam int NEED_W  = BRK_W + 1;                // break plus header plus size
    localparam int STAT_W  = 2;

    // request kinds
    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_SIZE  = 2'd1,
        STAT_EXHAUSTED = 2'd2,
        STAT_UNKNOWN   = 2'd3
    } status_t;

    // one block header as kept in the data memory
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic              is_free;
    } entry_t;

    // write requests from the sequencer to the two memories
    typedef struct packed {
        logic              data_we;
        logic [SLOT_W-1:0] data_addr;
        entry_t            data_word;
        logic              succ_we;
        logic [SLOT_W-1:0] succ_addr;
        logic [SLOT_W-1:0] succ_word;
    } mem_wr_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SPLIT,
        ST_APPEND,
        ST_LINK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/ffba_ram.sv =====
// generic single-write, single-read synchronous ram with a registered read output
// no package dependency
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ffba_ctrl.sv =====
// list walk sequencer: first-fit search, split, append, free, result register
// depends on ffba_pkg; drives the data and successor memories
`timescale 1ns / 1ps

module ffba_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    // request side
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_mode,
    input  logic [ffba_pkg::ADDR_W-1:0] s_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0] s_release_address,
    // result side
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [ffba_pkg::ADDR_W-1:0] m_grant_address,
    output logic [ffba_pkg::STAT_W-1:0] m_status,
    // memories
    output logic [ffba_pkg::SLOT_W-1:0] rd_addr,
    input  ffba_pkg::entry_t        rd_entry,
    input  logic [ffba_pkg::SLOT_W-1:0] rd_succ,
    output ffba_pkg::mem_wr_t       wr
);
    import ffba_pkg::*;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [ADDR_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   slots_reg, slots_next;
    logic [SLOT_W-1:0]  tail_reg, tail_next;
    logic [BRK_W-1:0]   brk_reg, brk_next;
    logic [SLOT_W-1:0]  new_slot_reg, new_slot_next;
    logic [ADDR_W-1:0]  hit_start_reg, hit_start_next;
    logic [ADDR_W-1:0]  hit_len_reg, hit_len_next;
    logic [SLOT_W-1:0]  hit_succ_reg, hit_succ_next;
    logic [ADDR_W-1:0]  grant_reg, grant_next;
    status_t            status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]  m_grant_reg, m_grant_next;
    status_t            m_status_reg, m_status_next;

    logic [ADDR_W:0]    payload_addr;
    logic [ADDR_W:0]    size_hdr;
    logic               fit, split_ok, walk_end, free_hit;
    logic [NEED_W-1:0]  need_bytes;
    logic               append_fail;
    logic               accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);
    assign s_tready = (state_reg == ST_IDLE);

    assign payload_addr = {1'b0, rd_entry.start} + (ADDR_W+1)'(HEADER_BYTES);
    assign size_hdr     = {1'b0, size_reg} + (ADDR_W+1)'(HEADER_BYTES);
    assign fit      = rd_entry.is_free && (rd_entry.length >= size_reg);
    assign split_ok = ({1'b0, rd_entry.length} >= size_hdr)
                      && (slots_reg < CNT_W'(MAX_BLOCKS));
    assign free_hit = (payload_addr == {1'b0, addr_reg});
    assign walk_end = (cur_reg == tail_reg) || ((n_reg + CNT_W'(1)) == slots_reg);
    assign need_bytes  = NEED_W'(brk_reg) + NEED_W'(HEADER_BYTES) + NEED_W'(size_reg);
    assign append_fail = (slots_reg >= CNT_W'(MAX_BLOCKS))
                         || (need_bytes > NEED_W'(HEAP_BYTES));

    // the walk reads the successor of the entry under test every cycle
    assign rd_addr = (state_reg == ST_WALK) ? rd_succ : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slots_reg   <= '0;
            tail_reg    <= '0;
            brk_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slots_reg   <= slots_next;
            tail_reg    <= tail_next;
            brk_reg     <= brk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        cur_reg       <= cur_next;
        n_reg         <= n_next;
        new_slot_reg  <= new_slot_next;
        hit_start_reg <= hit_start_next;
        hit_len_reg   <= hit_len_next;
        hit_succ_reg  <= hit_succ_next;
        grant_reg     <= grant_next;
        status_reg    <= status_next;
        m_grant_reg   <= m_grant_next;
        m_status_reg  <= m_status_next;
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        slots_next     = slots_reg;
        tail_next      = tail_reg;
        brk_next       = brk_reg;
        new_slot_next  = new_slot_reg;
        hit_start_next = hit_start_reg;
        hit_len_next   = hit_len_reg;
        hit_succ_next  = hit_succ_reg;
        grant_next     = grant_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg;
        m_grant_next   = m_grant_reg;
        m_status_next  = m_status_reg;
        wr             = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next   = mode_t'(s_mode);
                    size_next   = s_request_size;
                    addr_next   = s_release_address;
                    cur_next    = '0;
                    n_next      = '0;
                    grant_next  = '0;
                    status_next = STAT_OK;
                    if (mode_t'(s_mode) == MODE_ALLOC && s_request_size == '0) begin
                        status_next = STAT_BAD_SIZE;
                        state_next  = ST_DONE;
                    end else if (slots_reg == '0) begin
                        if (mode_t'(s_mode) == MODE_ALLOC) begin
                            state_next = ST_APPEND;
                        end else begin
                            status_next = STAT_UNKNOWN;
                            state_next  = ST_DONE;
                        end
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                if (mode_reg == MODE_FREE && free_hit) begin
                    wr.data_we           = 1'b1;
                    wr.data_addr         = cur_reg;
                    wr.data_word         = rd_entry;
                    wr.data_word.is_free = 1'b1;
                    state_next           = ST_DONE;
                end else if (mode_reg == MODE_ALLOC && fit) begin
                    grant_next           = payload_addr[ADDR_W-1:0];
                    wr.data_we           = 1'b1;
                    wr.data_addr         = cur_reg;
                    wr.data_word         = rd_entry;
                    wr.data_word.is_free = 1'b0;
                    state_next           = ST_DONE;
                    if (split_ok) begin
                        wr.data_word.length = size_reg;
                        wr.succ_we          = 1'b1;
                        wr.succ_addr        = cur_reg;
                        wr.succ_word        = slots_reg[SLOT_W-1:0];
                        new_slot_next       = slots_reg[SLOT_W-1:0];
                        hit_start_next      = rd_entry.start;
                        hit_len_next        = rd_entry.length;
                        hit_succ_next       = rd_succ;
                        slots_next          = slots_reg + CNT_W'(1);
                        if (tail_reg == cur_reg) begin
                            tail_next = slots_reg[SLOT_W-1:0];
                        end
                        state_next = ST_SPLIT;
                    end
                end else if (walk_end) begin
                    if (mode_reg == MODE_ALLOC) begin
                        state_next = ST_APPEND;
                    end else begin
                        status_next = STAT_UNKNOWN;
                        state_next  = ST_DONE;
                    end
                end else begin
                    cur_next = rd_succ;
                    n_next   = n_reg + CNT_W'(1);
                end
            end

            ST_SPLIT: begin
                // remainder block right after the granted payload
                wr.data_we           = 1'b1;
                wr.data_addr         = new_slot_reg;
                wr.data_word.start   = hit_start_reg + ADDR_W'(HEADER_BYTES) + size_reg;
                wr.data_word.length  = hit_len_reg - size_reg - ADDR_W'(HEADER_BYTES);
                wr.data_word.is_free = 1'b1;
                wr.succ_we           = 1'b1;
                wr.succ_addr         = new_slot_reg;
                wr.succ_word         = hit_succ_reg;
                state_next           = ST_DONE;
            end

            ST_APPEND: begin
                if (append_fail) begin
                    status_next = STAT_EXHAUSTED;
                    state_next  = ST_DONE;
                end else begin
                    wr.data_we           = 1'b1;
                    wr.data_addr         = slots_reg[SLOT_W-1:0];
                    wr.data_word.start   = brk_reg[ADDR_W-1:0];
                    wr.data_word.length  = size_reg;
                    wr.data_word.is_free = 1'b0;
                    wr.succ_we           = 1'b1;
                    wr.succ_addr         = slots_reg[SLOT_W-1:0];
                    wr.succ_word         = '0;
                    grant_next    = brk_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                    new_slot_next = slots_reg[SLOT_W-1:0];
                    slots_next    = slots_reg + CNT_W'(1);
                    brk_next      = need_bytes[BRK_W-1:0];
                    if (slots_reg == '0) begin
                        tail_next  = slots_reg[SLOT_W-1:0];
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_LINK;
                    end
                end
            end

            ST_LINK: begin
                // hook the new block behind the old tail
                wr.succ_we   = 1'b1;
                wr.succ_addr = tail_reg;
                wr.succ_word = new_slot_reg;
                tail_next    = new_slot_reg;
                state_next   = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_grant_next  = grant_reg;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid        = m_valid_reg;
    assign m_grant_address = m_grant_reg;
    assign m_status        = m_status_reg;

endmodule

// ===== rtl/first_fit_block_allocator_core.sv =====
// top level of the first-fit block allocator: stream ports, two header memories
// depends on ffba_pkg, ffba_ram and ffba_ctrl
`timescale 1ns / 1ps

// channel   dir   fields                                         handshake
// s_        in    tuser: mode; tdata: request_size, release_addr  s_tvalid / s_tready
// m_        out   tdata: grant_address, status                   m_tvalid / m_tready
//
// one request at a time: accept in ST_IDLE, then a walk over the list entries visited
// (up to MAX_BLOCKS), then ST_SPLIT, or ST_APPEND and ST_LINK writes, then ST_DONE loads the result register
// the walk pace is set by the registered read of the header memories
// aresetn clears slot count, tail and heap break; memories are never cleared
// a held result (m_tready low) lets the next request in and stalls it only at the end

module first_fit_block_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] release_address
    input  logic        s_tuser,   // [0] mode: 0 allocate, 1 free
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] grant_address, [17:16] status, rest zero
);
    import ffba_pkg::*;

    logic [SLOT_W-1:0]       rd_addr;
    logic [$bits(entry_t)-1:0] data_rd;
    logic [SLOT_W-1:0]       succ_rd;
    entry_t                  rd_entry;
    mem_wr_t                 wr;
    logic [ADDR_W-1:0]       grant_address;
    logic [STAT_W-1:0]       status;

    assign rd_entry = entry_t'(data_rd);

    // block start, payload length and free mark per slot
    ffba_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (wr.data_we),
        .waddr (wr.data_addr),
        .wdata (wr.data_word),
        .raddr (rd_addr),
        .rdata (data_rd)
    );

    // successor slot in address order
    ffba_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_succ_ram (
        .aclk  (aclk),
        .we    (wr.succ_we),
        .waddr (wr.succ_addr),
        .wdata (wr.succ_word),
        .raddr (rd_addr),
        .rdata (succ_rd)
    );

    ffba_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_mode            (s_tuser),
        .s_request_size    (s_tdata[15:0]),
        .s_release_address (s_tdata[31:16]),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_grant_address   (grant_address),
        .m_status          (status),
        .rd_addr           (rd_addr),
        .rd_entry          (rd_entry),
        .rd_succ           (succ_rd),
        .wr                (wr)
    );

    // pack the result, zero fill to whole bytes
    assign m_tdata = {6'b0, status, grant_address};

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for first_fit_block_allocator_core
// carries its own allocator predictor; depends on ffba_pkg and the rtl sources
`timescale 1ns / 1ps

module testbench;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_PER_PHASE = 345;
    localparam int DRAIN_CYCLES     = MAX_BLOCKS + 16;
    localparam int HOLDOFF_CYCLES   = 400;
    localparam int DIRECTED_ROWS    = 21;

    typedef struct packed {
        logic [ADDR_W-1:0] grant;
        status_t           status;
    } grant_result_t;

    typedef struct packed {
        mode_t             mode;
        logic [15:0]       size;
        logic [15:0]       addr;
        logic              typed;
        logic [ADDR_W-1:0] grant;
        status_t           status;
    } directed_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    first_fit_block_allocator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // predictor state: header list, slot count, tail and heap break
    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_len   [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    logic [SLOT_W-1:0] blk_next  [MAX_BLOCKS];
    logic [CNT_W-1:0]  slots_used = '0;
    logic [SLOT_W-1:0] tail_blk   = '0;
    logic [BRK_W-1:0]  heap_top   = '0;

    grant_result_t     pending_grants [$];
    logic [ADDR_W-1:0] live_addrs [$];
    logic [ADDR_W-1:0] freed_addrs [$];

    int mismatch_count   = 0;
    int cycle_count      = 0;
    int sender_idle_pct  = 0;
    int receiver_idle_pct = 0;
    int holdoff_asked    = 0;
    int holdoff_taken    = 0;
    int holdoff_left     = 0;

    function automatic grant_result_t allocator_step(mode_t mode, logic [15:0] size,
                                                     logic [15:0] addr);
        grant_result_t     r;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] slot;
        int                n;
        r.grant  = '0;
        r.status = STAT_OK;
        cur      = '0;
        if (mode == MODE_FREE) begin
            for (n = 0; n < slots_used; n++) begin
                if (blk_start[cur] + HEADER_BYTES == addr) begin
                    blk_free[cur] = 1'b1;
                    return r;
                end
                if (cur == tail_blk) break;
                cur = blk_next[cur];
            end
            r.status = STAT_UNKNOWN;
            return r;
        end
        if (size == 0) begin
            r.status = STAT_BAD_SIZE;
            return r;
        end
        // first fit along the address-ordered list
        for (n = 0; n < slots_used; n++) begin
            if (blk_free[cur] && blk_len[cur] >= size) begin
                // split only when a header fits behind and a slot is left
                if (blk_len[cur] >= size + HEADER_BYTES && slots_used < MAX_BLOCKS) begin
                    slot            = SLOT_W'(slots_used);
                    blk_start[slot] = ADDR_W'(blk_start[cur] + HEADER_BYTES + size);
                    blk_len[slot]   = ADDR_W'(blk_len[cur] - size - HEADER_BYTES);
                    blk_free[slot]  = 1'b1;
                    blk_next[slot]  = blk_next[cur];
                    blk_next[cur]   = slot;
                    if (tail_blk == cur) tail_blk = slot;
                    blk_len[cur]    = size;
                    slots_used++;
                end
                blk_free[cur] = 1'b0;
                r.grant = ADDR_W'(blk_start[cur] + HEADER_BYTES);
                return r;
            end
            if (cur == tail_blk) break;
            cur = blk_next[cur];
        end
        // no fit: grow the break
        if (slots_used >= MAX_BLOCKS || heap_top + HEADER_BYTES + size > HEAP_BYTES) begin
            r.status = STAT_EXHAUSTED;
            return r;
        end
        slot            = SLOT_W'(slots_used);
        blk_start[slot] = ADDR_W'(heap_top);
        blk_len[slot]   = size;
        blk_free[slot]  = 1'b0;
        blk_next[slot]  = '0;
        if (slots_used > 0) blk_next[tail_blk] = slot;
        tail_blk = slot;
        slots_used++;
        heap_top = BRK_W'(heap_top + HEADER_BYTES + size);
        r.grant  = ADDR_W'(blk_start[slot] + HEADER_BYTES);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    // drives one request at the falling edge, predicts it once accepted
    task automatic offer_request(input mode_t mode, input logic [15:0] size,
                                 input logic [15:0] addr, input logic typed,
                                 input grant_result_t typed_result);
        grant_result_t predicted;
        int            k;
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {addr, size};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = allocator_step(mode, size, addr);
        pending_grants.push_back(typed ? typed_result : predicted);
        if (predicted.status == STAT_OK) begin
            if (mode == MODE_ALLOC) begin
                live_addrs.push_back(predicted.grant);
            end else begin
                for (k = 0; k < live_addrs.size(); k++) begin
                    if (live_addrs[k] == addr) begin
                        live_addrs.delete(k);
                        break;
                    end
                end
                freed_addrs.push_back(addr);
                if (freed_addrs.size() > MAX_BLOCKS) void'(freed_addrs.pop_front());
            end
        end
    endtask

    // receiver readiness, with an occasional long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (holdoff_asked != holdoff_taken) begin
                holdoff_taken = holdoff_asked;
                holdoff_left  = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        grant_result_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                note_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
            end else begin
                head = pending_grants.pop_front();
                if (m_tdata[15:0] !== head.grant)
                    note_mismatch($sformatf("grant_address exp %h got %h",
                                            head.grant, m_tdata[15:0]));
                if (m_tdata[17:16] !== head.status)
                    note_mismatch($sformatf("status exp %0d got %0d",
                                            head.status, m_tdata[17:16]));
                if (m_tdata[23:18] !== '0)
                    note_mismatch($sformatf("padding bits set tdata=%h", m_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // directed rows; typed expectations only where obvious
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_FREE,  16'd0,     16'h1234, 1'b1, 16'd0,  STAT_UNKNOWN},   // free on empty heap
        '{MODE_ALLOC, 16'd0,     16'd0,    1'b1, 16'd0,  STAT_BAD_SIZE},  // zero request
        '{MODE_ALLOC, 16'hFFFF,  16'd0,    1'b1, 16'd0,  STAT_EXHAUSTED}, // largest request
        '{MODE_ALLOC, 16'd1,     16'd0,    1'b1, 16'd32, STAT_OK},        // first block
        '{MODE_ALLOC, 16'd16,    16'd0,    1'b0, 16'd0,  STAT_OK},
        '{MODE_FREE,  16'd0,     16'd32,   1'b1, 16'd0,  STAT_OK},
        '{MODE_FREE,  16'd0,     16'd32,   1'b1, 16'd0,  STAT_OK},        // already free
        '{MODE_ALLOC, 16'd1,     16'd0,    1'b0, 16'd0,  STAT_OK},        // reuse, no split
        '{MODE_FREE,  16'd0,     16'd65,   1'b1, 16'd0,  STAT_OK},
        '{MODE_ALLOC, 16'd16,    16'd0,    1'b0, 16'd0,  STAT_OK},
        '{MODE_ALLOC, 16'd4000,  16'd0,    1'b0, 16'd0,  STAT_OK},
        '{MODE_FREE,  16'd0,     16'd113,  1'b1, 16'd0,  STAT_OK},
        '{MODE_ALLOC, 16'd100,   16'd0,    1'b0, 16'd0,  STAT_OK},        // split
        '{MODE_ALLOC, 16'd3836,  16'd0,    1'b0, 16'd0,  STAT_OK},        // empty remainder
        '{MODE_ALLOC, 16'd1,     16'd0,    1'b0, 16'd0,  STAT_OK},        // walk then append
        '{MODE_ALLOC, 16'd61359, 16'd0,    1'b1, 16'd0,  STAT_EXHAUSTED}, // one byte too many
        '{MODE_FREE,  16'hFFFF,  16'hFFFF, 1'b1, 16'd0,  STAT_UNKNOWN},
        '{MODE_FREE,  16'd0,     16'd0,    1'b1, 16'd0,  STAT_UNKNOWN},
        '{MODE_ALLOC, 16'd0,     16'hFFFF, 1'b1, 16'd0,  STAT_BAD_SIZE},
        '{MODE_FREE,  16'h5A5A,  16'd245,  1'b1, 16'd0,  STAT_OK},
        '{MODE_FREE,  16'd0,     16'd4145, 1'b1, 16'd0,  STAT_OK}
    };

    initial begin : stimulus
        int            i;
        int            phase;
        int            pick;
        mode_t         mode;
        logic [15:0]   size;
        logic [15:0]   addr;
        grant_result_t typed_result;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct   = 20;
        receiver_idle_pct = 88;
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            typed_result.grant  = directed_rows[i].grant;
            typed_result.status = directed_rows[i].status;
            offer_request(directed_rows[i].mode, directed_rows[i].size,
                          directed_rows[i].addr, directed_rows[i].typed, typed_result);
        end

        typed_result = '0;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 20;
                    receiver_idle_pct = 88;
                end
                1: begin
                    sender_idle_pct   = 88;
                    receiver_idle_pct = 20;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (i = 0; i < RANDOM_PER_PHASE; i++) begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 2 && i == 100) holdoff_asked++;
                pick = $urandom_range(99);
                size = 16'($urandom_range(0, 65535));
                addr = 16'($urandom_range(0, 65535));
                if (pick < 55 || (pick < 90 && live_addrs.size() == 0)) begin
                    mode = MODE_ALLOC;
                    pick = $urandom_range(99);
                    if (pick < 70) size = 16'($urandom_range(1, 128));
                    else if (pick < 85) size = 16'($urandom_range(1, 2048));
                    else if (pick >= 96) size = 16'd0;
                end else if (pick < 90) begin
                    mode = MODE_FREE;
                    addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
                end else if (pick < 95 && freed_addrs.size() != 0) begin
                    mode = MODE_FREE;
                    addr = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
                end else begin
                    mode = MODE_FREE;
                end
                offer_request(mode, size, addr, 1'b0, typed_result);
            end
            // sender pauses until every pending result is back
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while (pending_grants.size() != 0) @(posedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator_core.sv
sim/testbench.sv
